/* src/line_edit_buffer_top_assert.svh */
// Assertion macros for the line edit buffer.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef LINE_EDIT_BUFFER_TOP_ASSERT_SVH
`define LINE_EDIT_BUFFER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every edge out of reset.
`define LEB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("line edit buffer check failed");
// Condition in one cycle implies a consequence in the next.
`define LEB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line edit buffer sequence check failed");
`else
`define LEB_ASSERT(lbl, prop)
`define LEB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* src/leb_pkg.sv */
// Shared types and constants for the line edit buffer.
// No dependencies; imported by the top level and by leb_ctrl.
`default_nettype none

package leb_pkg;

    localparam int LINE_DEPTH = 64;
    localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CAP_W      = 7;
    localparam int POS_W      = 6;
    localparam int CHAR_W     = 8;
    localparam int MODE_W     = 4;

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 3;

    localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;
    localparam logic [CHAR_W-1:0] CHAR_LO   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_HI   = 8'h7E;

    // key modes
    localparam logic [MODE_W-1:0] M_START   = 4'd0;
    localparam logic [MODE_W-1:0] M_PRELOAD = 4'd1;
    localparam logic [MODE_W-1:0] M_TYPED   = 4'd2;
    localparam logic [MODE_W-1:0] M_ESC     = 4'd3;
    localparam logic [MODE_W-1:0] M_ENTER   = 4'd4;
    localparam logic [MODE_W-1:0] M_LEFT    = 4'd5;
    localparam logic [MODE_W-1:0] M_RIGHT   = 4'd6;
    localparam logic [MODE_W-1:0] M_BKSP    = 4'd7;
    localparam logic [MODE_W-1:0] M_DEL     = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MOVE,
        ST_INSERT,
        ST_FINISH,
        ST_ENTER
    } state_t;

    typedef struct packed {
        logic              done_res;
        logic              accepted;
        logic              illegal_key;
        logic [POS_W-1:0]  cursor_pos;
        logic [POS_W-1:0]  line_length;
        logic [CHAR_W-1:0] char_out;
        logic [POS_W-1:0]  char_index;
        logic              last;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [CHAR_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

endpackage

`default_nettype wire

/* src/line_edit_buffer_top.sv */
// Top level of the line edit buffer: stream ports, capacity register,
// result register. Depends on leb_pkg, leb_ctrl and leb_line_ram.
//
// Usage:
//   Keys arrive on the s_axis channel, one transaction per key: tuser carries
//   the mode (start, preload, typed, escape, enter, left, right, backspace,
//   delete), tdata the character. Results leave on m_axis. Every key gives
//   one result with tlast set, except enter, which streams one result per
//   held character (tlast on the final one), or one result on an empty line.
//   The user writes the capacity register (cfg) only while idle; not enforced.
// Timing:
//   One key is in flight at a time. A key that moves and streams no characters
//   passes from decode to finish, where its result is registered; the next
//   key is taken back in idle. Insert, backspace and delete shift the tail
//   one character per cycle through the line RAM (insert then writes the
//   key) before finish registers the result. Enter streams one character
//   per cycle while the output register is free.
// Reset:
//   Empty line, cursor 0, first-key flag armed, capacity 64. The line RAM
//   is not cleared; only written slots are ever read.
// Back-pressure:
//   A held result waits in the output register; the next key is still taken
//   and processed up to its own result, which waits until the register frees.
`default_nettype none

module line_edit_buffer_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // key channel
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [leb_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [7:0] key_char
    input  wire logic [leb_pkg::IN_USER_W-1:0]     s_axis_tuser,  // [3:0] mode
    // result channel
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [5:0] cursor_pos, [11:6] line_length, [19:12] char_out,
    // [25:20] char_index, [31:26] zero
    output logic      [leb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] done_res, [1] accepted, [2] illegal_key
    output logic      [leb_pkg::OUT_USER_W-1:0]    m_axis_tuser,
    output logic                                   m_axis_tlast,
    // capacity write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [leb_pkg::CAP_W-1:0]         cfg_data
);

    import leb_pkg::*;

    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg;
    logic              out_free;
    logic              push;
    result_t           res;
    mem_req_t          mem;
    logic [CHAR_W-1:0] rd_data;

    // capacity register; writes are always taken
    assign cfg_ready = 1'b1;
    assign cap_next  = (cfg_valid && cfg_ready) ? cfg_data : cap_reg;

    // output register frees when empty or being drained this cycle
    assign out_free       = !out_valid_reg || m_axis_tready;
    assign out_valid_next = push || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_res_reg <= res;
        end
    end

    leb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_mode  (s_axis_tuser[MODE_W-1:0]),
        .in_key   (s_axis_tdata[CHAR_W-1:0]),
        .cap      (cap_reg),
        .out_free (out_free),
        .push     (push),
        .res      (res),
        .mem      (mem),
        .rd_data  (rd_data)
    );

    leb_line_ram #(
        .DEPTH (LINE_DEPTH),
        .WIDTH (CHAR_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .re    (mem.re),
        .raddr (mem.raddr),
        .rdata (rd_data)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_res_reg.char_index, out_res_reg.char_out,
                                        out_res_reg.line_length, out_res_reg.cursor_pos});
    assign m_axis_tuser  = {out_res_reg.illegal_key, out_res_reg.accepted,
                            out_res_reg.done_res};
    assign m_axis_tlast  = out_res_reg.last;

endmodule

`default_nettype wire

/* src/leb_line_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// Standalone; sized by its parameters.
`default_nettype none

module leb_line_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds when no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/leb_ctrl.sv */
// Edit sequencer: decodes keys, moves line characters through the RAM,
// streams the accepted line. Depends on leb_pkg and the assertion header.
`default_nettype none
`include "line_edit_buffer_top_assert.svh"

module leb_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [leb_pkg::MODE_W-1:0]    in_mode,
    input  wire logic [leb_pkg::CHAR_W-1:0]    in_key,
    input  wire logic [leb_pkg::CAP_W-1:0]     cap,
    input  wire logic                          out_free,
    output logic                               push,
    output leb_pkg::result_t                   res,
    output leb_pkg::mem_req_t                  mem,
    input  wire logic [leb_pkg::CHAR_W-1:0]    rd_data
);

    import leb_pkg::*;

    state_t             state_reg, state_next;
    logic [MODE_W-1:0]  mode_reg;
    logic [CHAR_W-1:0]  key_reg;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [IDX_W-1:0]   len_reg, len_next;
    logic               first_reg, first_next;
    logic [IDX_W-1:0]   mv_src_reg, mv_src_next;
    logic [IDX_W-1:0]   mv_cnt_reg, mv_cnt_next;
    logic               mv_right_reg, mv_right_next;
    logic               wpend_reg, wpend_next;
    logic [IDX_W-1:0]   wdst_reg, wdst_next;
    logic               ins_reg, ins_next;
    logic [IDX_W-1:0]   ins_addr_reg, ins_addr_next;
    logic [IDX_W-1:0]   em_idx_reg, em_idx_next;
    logic               rdv_reg, rdv_next;
    logic               rdone_reg, rdone_next;
    logic               racc_reg, racc_next;
    logic               rill_reg, rill_next;

    // decode of the held key
    logic [CAP_W-1:0]   cap_eff;
    logic [IDX_W-1:0]   l0, c0, c_right;
    logic               printable, room_len, room_l0;
    logic [IDX_W-1:0]   dec_cur, dec_len, dec_src, dec_cnt;
    logic               dec_first, dec_done, dec_acc, dec_ill;
    logic               dec_move, dec_ins, dec_wr, dec_right, dec_enter;
    logic               em_last, mv_busy;

    always_comb
    begin
        cap_eff   = (cap > CAP_W'(LINE_DEPTH)) ? CAP_W'(LINE_DEPTH) : cap;
        l0        = first_reg ? '0 : len_reg;
        c0        = first_reg ? '0 : cur_reg;
        c_right   = first_reg ? ((len_reg != '0) ? len_reg - IDX_W'(1) : '0) : cur_reg;
        printable = (key_reg >= CHAR_LO) && (key_reg <= CHAR_HI);
        room_len  = (CAP_W'(len_reg) + CAP_W'(1)) < cap_eff;
        room_l0   = (CAP_W'(l0) + CAP_W'(1)) < cap_eff;

        dec_cur   = cur_reg;
        dec_len   = len_reg;
        dec_first = first_reg;
        dec_done  = 1'b0;
        dec_acc   = 1'b0;
        dec_ill   = 1'b0;
        dec_move  = 1'b0;
        dec_ins   = 1'b0;
        dec_wr    = 1'b0;
        dec_right = 1'b0;
        dec_enter = 1'b0;
        dec_src   = cur_reg;
        dec_cnt   = '0;

        unique case (mode_reg)
            M_START:
            begin
                dec_cur   = '0;
                dec_len   = '0;
                dec_first = 1'b1;
            end
            M_PRELOAD:
            begin
                if ((key_reg != '0) && room_len)
                begin
                    dec_wr  = 1'b1;
                    dec_len = len_reg + IDX_W'(1);
                end
            end
            M_TYPED:
            begin
                dec_first = 1'b0;
                if (!printable)
                begin
                    dec_ill = 1'b1;
                end
                else
                begin
                    dec_cur = c0;
                    dec_len = l0;
                    if (room_l0)
                    begin
                        // shift tail right from the end, then drop the key in
                        dec_move  = 1'b1;
                        dec_ins   = 1'b1;
                        dec_right = 1'b1;
                        dec_src   = l0 - IDX_W'(1);
                        dec_cnt   = l0 - c0;
                        dec_cur   = c0 + IDX_W'(1);
                        dec_len   = l0 + IDX_W'(1);
                    end
                end
            end
            M_ESC:
            begin
                dec_first = 1'b0;
                dec_cur   = '0;
                dec_done  = 1'b1;
            end
            M_ENTER:
            begin
                dec_first = 1'b0;
                dec_cur   = len_reg;
                dec_done  = 1'b1;
                dec_acc   = 1'b1;
                dec_enter = (len_reg != '0);
            end
            M_LEFT:
            begin
                dec_first = 1'b0;
                dec_cur   = (c0 != '0) ? c0 - IDX_W'(1) : c0;
            end
            M_RIGHT:
            begin
                dec_first = 1'b0;
                dec_cur   = (c_right < len_reg) ? c_right + IDX_W'(1) : c_right;
            end
            M_BKSP:
            begin
                dec_first = 1'b0;
                if (first_reg)
                begin
                    dec_cur = '0;
                    dec_len = '0;
                end
                else if (cur_reg != '0)
                begin
                    dec_move = 1'b1;
                    dec_src  = cur_reg;
                    dec_cnt  = len_reg - cur_reg;
                    dec_cur  = cur_reg - IDX_W'(1);
                    dec_len  = len_reg - IDX_W'(1);
                end
            end
            M_DEL:
            begin
                dec_first = 1'b0;
                if (first_reg)
                begin
                    dec_cur = '0;
                    dec_len = '0;
                end
                else if (cur_reg < len_reg)
                begin
                    dec_move = 1'b1;
                    dec_src  = cur_reg + IDX_W'(1);
                    dec_cnt  = len_reg - cur_reg - IDX_W'(1);
                    dec_len  = len_reg - IDX_W'(1);
                end
            end
            default:
            begin
                dec_first = first_reg;
            end
        endcase
    end

    assign em_last = (em_idx_reg == len_reg - IDX_W'(1));
    assign mv_busy = (mv_cnt_reg != '0) || wpend_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (dec_move)
                begin
                    state_next = ST_MOVE;
                end
                else if (dec_enter)
                begin
                    state_next = ST_ENTER;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MOVE:
            begin
                if (!mv_busy)
                begin
                    state_next = ins_reg ? ST_INSERT : ST_FINISH;
                end
            end
            ST_INSERT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ENTER:
            begin
                if (rdv_reg && out_free && em_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready        = 1'b0;
        push            = 1'b0;
        res.done_res    = rdone_reg;
        res.accepted    = racc_reg;
        res.illegal_key = rill_reg;
        res.cursor_pos  = POS_W'(cur_reg);
        res.line_length = POS_W'(len_reg);
        res.char_out    = '0;
        res.char_index  = '0;
        res.last        = 1'b1;
        mem.we          = 1'b0;
        mem.waddr       = wdst_reg;
        mem.wdata       = rd_data;
        mem.re          = 1'b0;
        mem.raddr       = mv_src_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_DECODE:
            begin
                // preload appends in place
                mem.we    = dec_wr;
                mem.waddr = len_reg;
                mem.wdata = key_reg;
            end
            ST_MOVE:
            begin
                mem.re = (mv_cnt_reg != '0);
                mem.we = wpend_reg;
            end
            ST_INSERT:
            begin
                mem.we    = 1'b1;
                mem.waddr = ins_addr_reg;
                mem.wdata = key_reg;
            end
            ST_FINISH:
            begin
                push = out_free;
            end
            ST_ENTER:
            begin
                push           = rdv_reg && out_free;
                res.char_out   = rd_data;
                res.char_index = POS_W'(em_idx_reg);
                res.last       = em_last;
                mem.re         = !rdv_reg || (out_free && !em_last);
                mem.raddr      = rdv_reg ? em_idx_reg + IDX_W'(1) : em_idx_reg;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        cur_next      = cur_reg;
        len_next      = len_reg;
        first_next    = first_reg;
        mv_src_next   = mv_src_reg;
        mv_cnt_next   = mv_cnt_reg;
        mv_right_next = mv_right_reg;
        wpend_next    = wpend_reg;
        wdst_next     = wdst_reg;
        ins_next      = ins_reg;
        ins_addr_next = ins_addr_reg;
        em_idx_next   = em_idx_reg;
        rdv_next      = rdv_reg;
        rdone_next    = rdone_reg;
        racc_next     = racc_reg;
        rill_next     = rill_reg;
        case (state_reg)
            ST_DECODE:
            begin
                cur_next      = dec_cur;
                len_next      = dec_len;
                first_next    = dec_first;
                mv_src_next   = dec_src;
                mv_cnt_next   = dec_cnt;
                mv_right_next = dec_right;
                wpend_next    = 1'b0;
                ins_next      = dec_ins;
                ins_addr_next = c0;
                em_idx_next   = '0;
                rdv_next      = 1'b0;
                rdone_next    = dec_done;
                racc_next     = dec_acc;
                rill_next     = dec_ill;
            end
            ST_MOVE:
            begin
                // read one slot per cycle; write it one place over in the next cycle
                wpend_next = (mv_cnt_reg != '0);
                if (mv_cnt_reg != '0)
                begin
                    mv_cnt_next = mv_cnt_reg - IDX_W'(1);
                    mv_src_next = mv_right_reg ? mv_src_reg - IDX_W'(1)
                                               : mv_src_reg + IDX_W'(1);
                    wdst_next   = mv_right_reg ? mv_src_reg + IDX_W'(1)
                                               : mv_src_reg - IDX_W'(1);
                end
            end
            ST_ENTER:
            begin
                if (!rdv_reg)
                begin
                    rdv_next = 1'b1;
                end
                else if (out_free && !em_last)
                begin
                    em_idx_next = em_idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                rdv_next = rdv_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cur_reg    <= '0;
            len_reg    <= '0;
            first_reg  <= 1'b1;
            mv_cnt_reg <= '0;
            wpend_reg  <= 1'b0;
            ins_reg    <= 1'b0;
            rdv_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            len_reg    <= len_next;
            first_reg  <= first_next;
            mv_cnt_reg <= mv_cnt_next;
            wpend_reg  <= wpend_next;
            ins_reg    <= ins_next;
            rdv_reg    <= rdv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= in_mode;
            key_reg  <= in_key;
        end
        mv_src_reg   <= mv_src_next;
        mv_right_reg <= mv_right_next;
        wdst_reg     <= wdst_next;
        ins_addr_reg <= ins_addr_next;
        em_idx_reg   <= em_idx_next;
        rdone_reg    <= rdone_next;
        racc_reg     <= racc_next;
        rill_reg     <= rill_next;
    end

    `LEB_ASSERT(a_cur_within_len, cur_reg <= len_reg)
    `LEB_ASSERT(a_no_rw_same_slot, !(mem.we && mem.re && (mem.waddr == mem.raddr)))
    `LEB_ASSERT_NEXT(a_last_ends_item, push && res.last, state_reg == ST_IDLE)

endmodule

`default_nettype wire
